@@ design/sptr_pkg.sv @@
// ----------------------------------------------------------------------------
// sptr_pkg
// Shared types and constants for the sparse triplet fast transpose block.
// ----------------------------------------------------------------------------
package sptr_pkg;

  localparam int MAX_TERMS = 63;
  localparam int MAX_DIM   = 64;

  localparam int FLD_W   = 6;                        // row/col field width
  localparam int DIM_W   = $clog2(MAX_DIM);          // column table address
  localparam int CNT_W   = $clog2(MAX_TERMS + 1);    // term count, positions
  localparam int TA_W    = $clog2(2 * MAX_TERMS);    // triplet store address
  localparam int TDEPTH  = 2 * MAX_TERMS;            // terms, then sorted copy
  localparam int REG_W   = 7;
  localparam int VAL_W   = 32;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic                    has_term;
    logic [FLD_W-1:0]        term_row;
    logic [FLD_W-1:0]        term_col;
    logic signed [VAL_W-1:0] term_value;
    logic                    last_term;
  } in_item_t;

  typedef struct packed {
    logic                    is_header;
    logic [REG_W-1:0]        out_row;
    logic [REG_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    out_last;
  } out_item_t;

  typedef struct packed {
    logic [FLD_W-1:0] row;
    logic [FLD_W-1:0] col;
    logic [VAL_W-1:0] value;
  } triplet_t;

  localparam int TRIP_W = $bits(triplet_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_PREFIX,
    ST_SCATTER,
    ST_EMIT
  } state_t;

endpackage

@@ design/sparse_triplet_fast_transpose.sv @@
// ----------------------------------------------------------------------------
// sparse_triplet_fast_transpose
// Sparse matrix fast transpose over (row, column, value) triplets.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------
//   in       | in  | in_valid / in_ready    | in_data  (in_item_t)
//   out      | out | out_valid / out_ready  | out_data (out_item_t)
//   cfg      | in  | cfg_write              | cfg_index, cfg_data
//
// Terms load one per cycle into the triplet store. After the last transfer
// come a column prefix pass, a scatter pass, emission of N+1 results at up
// to one per cycle, then a column table clear (also run after reset) before
// in_ready rises. All passes are bound by the single read and write port of
// each RAM. Output stalls only hold the emission pass.
// ----------------------------------------------------------------------------
module sparse_triplet_fast_transpose (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sptr_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sptr_pkg::out_item_t          out_data,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [sptr_pkg::REG_W-1:0]   cfg_data
);
  import sptr_pkg::*;

  logic [REG_W-1:0]  row_count;
  logic [REG_W-1:0]  col_count;

  logic              tram_we;
  logic [TA_W-1:0]   tram_waddr;
  logic [TRIP_W-1:0] tram_wdata;
  logic              tram_re;
  logic [TA_W-1:0]   tram_raddr;
  logic [TRIP_W-1:0] tram_rdata;
  logic              cram_we;
  logic [DIM_W-1:0]  cram_waddr;
  logic [CNT_W-1:0]  cram_wdata;
  logic              cram_re;
  logic [DIM_W-1:0]  cram_raddr;
  logic [CNT_W-1:0]  cram_rdata;
  logic              q_push;
  out_item_t         q_item;
  logic [1:0]        q_count;
  logic              q_pop;

  assign q_pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= REG_W'(MAX_DIM);
      col_count <= REG_W'(MAX_DIM);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  sptr_ram #(.ADDR_W(TA_W), .DATA_W(TRIP_W), .DEPTH(TDEPTH)) u_tram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (tram_waddr),
    .wdata (tram_wdata),
    .re    (tram_re),
    .raddr (tram_raddr),
    .rdata (tram_rdata)
  );

  sptr_ram #(.ADDR_W(DIM_W), .DATA_W(CNT_W), .DEPTH(MAX_DIM)) u_cram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (cram_waddr),
    .wdata (cram_wdata),
    .re    (cram_re),
    .raddr (cram_raddr),
    .rdata (cram_rdata)
  );

  sptr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .row_count  (row_count),
    .col_count  (col_count),
    .tram_we    (tram_we),
    .tram_waddr (tram_waddr),
    .tram_wdata (tram_wdata),
    .tram_re    (tram_re),
    .tram_raddr (tram_raddr),
    .tram_rdata (tram_rdata),
    .cram_we    (cram_we),
    .cram_waddr (cram_waddr),
    .cram_wdata (cram_wdata),
    .cram_re    (cram_re),
    .cram_raddr (cram_raddr),
    .cram_rdata (cram_rdata),
    .q_push     (q_push),
    .q_item     (q_item),
    .q_count    (q_count),
    .q_pop      (q_pop)
  );

  sptr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .valid     (out_valid),
    .ready     (out_ready),
    .item      (out_data),
    .count     (q_count)
  );

  // queue never overflows
  a_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count != 2'd2 || q_pop))
    else $error("result queue overflow");

  // a final transfer closes the input until the run is emitted and the column table cleared
  a_last_closes_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.last_term) |=> !in_ready)
    else $error("input open after final transfer");

  // header ends the run exactly when no terms were held
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_header) |-> (out_data.out_last == (out_data.out_value == 0)))
    else $error("header last flag inconsistent with term count");

endmodule

@@ design/sptr_ram.sv @@
// ----------------------------------------------------------------------------
// sptr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sptr_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/sptr_outq.sv @@
// ----------------------------------------------------------------------------
// sptr_outq
// Two-entry result queue between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module sptr_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sptr_pkg::out_item_t push_item,
  output logic                valid,
  input  logic                ready,
  output sptr_pkg::out_item_t item,
  output logic [1:0]          count
);
  import sptr_pkg::*;

  out_item_t slot [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic      pop;

  assign valid = (count != 2'd0);
  assign pop   = valid && ready;
  assign item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

@@ design/sptr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sptr_ctrl
// Sequencer: load, column prefix, scatter, emit and clear passes over the
// triplet store and the column table.
// ----------------------------------------------------------------------------
module sptr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sptr_pkg::in_item_t            in_data,
  input  logic [sptr_pkg::REG_W-1:0]    row_count,
  input  logic [sptr_pkg::REG_W-1:0]    col_count,
  output logic                          tram_we,
  output logic [sptr_pkg::TA_W-1:0]     tram_waddr,
  output logic [sptr_pkg::TRIP_W-1:0]   tram_wdata,
  output logic                          tram_re,
  output logic [sptr_pkg::TA_W-1:0]     tram_raddr,
  input  logic [sptr_pkg::TRIP_W-1:0]   tram_rdata,
  output logic                          cram_we,
  output logic [sptr_pkg::DIM_W-1:0]    cram_waddr,
  output logic [sptr_pkg::CNT_W-1:0]    cram_wdata,
  output logic                          cram_re,
  output logic [sptr_pkg::DIM_W-1:0]    cram_raddr,
  input  logic [sptr_pkg::CNT_W-1:0]    cram_rdata,
  output logic                          q_push,
  output sptr_pkg::out_item_t           q_item,
  input  logic [1:0]                    q_count,
  input  logic                          q_pop
);
  import sptr_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  loaded;
  logic [REG_W-1:0]  hdr_rows;
  logic [REG_W-1:0]  hdr_cols;

  logic              inc_v;
  logic [DIM_W-1:0]  inc_col;
  logic              pw_v;
  logic [DIM_W-1:0]  pw_addr;
  logic [CNT_W-1:0]  pw_data;
  logic [DIM_W-1:0]  rq_addr;
  logic [CNT_W-1:0]  cram_fwd;

  logic [DIM_W:0]    pc;
  logic              pv;
  logic [DIM_W-1:0]  paddr;
  logic [CNT_W-1:0]  run;

  logic [CNT_W-1:0]  sc;
  logic              s1_v;
  logic              s2_v;
  triplet_t          s2_term;
  triplet_t          trd;

  logic [CNT_W:0]    ec;
  logic              e_v;
  logic              e_hdr;
  logic              e_last;

  logic [DIM_W-1:0]  cc;

  logic              accept;
  logic              store;
  logic              prefix_rd;
  logic              prefix_done;
  logic              sc_issue;
  logic              scatter_done;
  logic              e_issue;
  logic              emit_done;
  logic              clear_done;

  assign trd      = triplet_t'(tram_rdata);
  assign cram_fwd = (pw_v && (pw_addr == rq_addr)) ? pw_data : cram_rdata;

  assign in_ready = (state == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign store    = accept && in_data.has_term
                    && ({1'b0, in_data.term_col} < col_count)
                    && ({1'b0, in_data.term_col} < REG_W'(MAX_DIM))
                    && (loaded < CNT_W'(MAX_TERMS));

  assign prefix_rd    = (state == ST_PREFIX) && (pc < (DIM_W + 1)'(MAX_DIM));
  assign prefix_done  = (state == ST_PREFIX) && (pc == (DIM_W + 1)'(MAX_DIM));
  assign sc_issue     = (state == ST_SCATTER) && (sc < loaded);
  assign scatter_done = (state == ST_SCATTER) && (sc == loaded) && !s1_v && !s2_v;
  assign e_issue      = (state == ST_EMIT) && (ec <= {1'b0, loaded})
                        && ((3'(q_count) + 3'(e_v)) <= (3'd1 + 3'(q_pop)));
  assign emit_done    = (state == ST_EMIT) && (ec > {1'b0, loaded}) && !e_v;
  assign clear_done   = (state == ST_CLEAR) && (cc == DIM_W'(MAX_DIM - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (clear_done) state_next = ST_LOAD;
      ST_LOAD:    if (accept && in_data.last_term) state_next = ST_PREFIX;
      ST_PREFIX:  if (prefix_done) state_next = ST_SCATTER;
      ST_SCATTER: if (scatter_done) state_next = ST_EMIT;
      ST_EMIT:    if (emit_done) state_next = ST_CLEAR;
      default:    state_next = ST_CLEAR;
    endcase
  end

  // memory and queue drive
  always_comb begin
    tram_we    = 1'b0;
    tram_waddr = TA_W'(in_data.term_col);
    tram_wdata = {in_data.term_row, in_data.term_col, in_data.term_value};
    tram_re    = 1'b0;
    tram_raddr = TA_W'(sc);
    cram_we    = 1'b0;
    cram_waddr = inc_col;
    cram_wdata = cram_fwd + CNT_W'(1);
    cram_re    = 1'b0;
    cram_raddr = in_data.term_col;

    if (store) begin
      tram_we    = 1'b1;
      tram_waddr = TA_W'(loaded);
      cram_re    = 1'b1;
    end
    if (prefix_rd) begin
      cram_re    = 1'b1;
      cram_raddr = pc[DIM_W-1:0];
    end
    if (sc_issue) begin
      tram_re    = 1'b1;
      tram_raddr = TA_W'(sc);
    end
    if (s1_v) begin
      cram_re    = 1'b1;
      cram_raddr = DIM_W'(trd.col);
    end
    if (e_issue) begin
      tram_re    = 1'b1;
      tram_raddr = TA_W'(MAX_TERMS - 1) + TA_W'(ec);
    end

    if (inc_v) begin
      cram_we    = 1'b1;
      cram_waddr = inc_col;
      cram_wdata = cram_fwd + CNT_W'(1);
    end
    if (pv) begin
      cram_we    = 1'b1;
      cram_waddr = paddr;
      cram_wdata = run;
    end
    if (s2_v) begin
      // row and column swap places in the sorted copy
      tram_we    = 1'b1;
      tram_waddr = TA_W'(MAX_TERMS) + TA_W'(cram_fwd);
      tram_wdata = {s2_term.col, s2_term.row, s2_term.value};
      cram_we    = 1'b1;
      cram_waddr = DIM_W'(s2_term.col);
      cram_wdata = cram_fwd + CNT_W'(1);
    end
    if (state == ST_CLEAR) begin
      cram_we    = 1'b1;
      cram_waddr = cc;
      cram_wdata = '0;
    end

    q_push = e_v;
    if (e_hdr) begin
      q_item = '{is_header: 1'b1, out_row: hdr_cols, out_col: hdr_rows,
                 out_value: VAL_W'(loaded), out_last: e_last};
    end else begin
      q_item = '{is_header: 1'b0, out_row: REG_W'(trd.row), out_col: REG_W'(trd.col),
                 out_value: trd.value, out_last: e_last};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      loaded <= '0;
      inc_v  <= 1'b0;
      pw_v   <= 1'b0;
      pc     <= '0;
      pv     <= 1'b0;
      run    <= '0;
      sc     <= '0;
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      ec     <= '0;
      e_v    <= 1'b0;
      cc     <= '0;
    end else begin
      state <= state_next;
      inc_v <= store;
      pw_v  <= cram_we;
      pv    <= prefix_rd;
      s1_v  <= sc_issue;
      s2_v  <= s1_v;
      e_v   <= e_issue;

      if (emit_done) begin
        loaded <= '0;
      end else if (store) begin
        loaded <= loaded + CNT_W'(1);
      end

      if (state == ST_PREFIX) begin
        pc <= pc + (DIM_W + 1)'(1);
      end else begin
        pc <= '0;
      end
      if (state != ST_PREFIX) begin
        run <= '0;
      end else if (pv) begin
        run <= run + cram_fwd;
      end

      if (state != ST_SCATTER) begin
        sc <= '0;
      end else if (sc_issue) begin
        sc <= sc + CNT_W'(1);
      end

      if (state != ST_EMIT) begin
        ec <= '0;
      end else if (e_issue) begin
        ec <= ec + (CNT_W + 1)'(1);
      end

      if (state == ST_CLEAR) begin
        cc <= cc + DIM_W'(1);
      end else begin
        cc <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    inc_col <= in_data.term_col;
    pw_addr <= cram_waddr;
    pw_data <= cram_wdata;
    paddr   <= pc[DIM_W-1:0];
    s2_term <= trd;
    e_hdr   <= (ec == '0);
    e_last  <= (ec == {1'b0, loaded});
    if (cram_re) begin
      rq_addr <= cram_raddr;
    end
    if (accept && in_data.last_term) begin
      hdr_rows <= row_count;
      hdr_cols <= col_count;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sparse_triplet_fast_transpose. Matrices of triplets are fed
// through the input channel, and each transposed result is checked against a
// transposed copy that the bench builds itself from the accepted triplets and
// the shape registers. Both channels idle at random, the receiver holds off
// once for a long stretch, and the shape registers change between phases and
// once in the middle of a matrix.
// ----------------------------------------------------------------------------
module tb_top;
  import sptr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_write = 1'b0;
  logic      cfg_index = REG_ROW_COUNT;
  logic [REG_W-1:0] cfg_data = '0;

  sparse_triplet_fast_transpose dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // bench copy of the block state
  logic [REG_W-1:0] shape_rows = 7'd64;
  logic [REG_W-1:0] shape_cols = 7'd64;
  triplet_t  held_terms[$];
  out_item_t transposed_due[$];

  in_item_t matrix_feed[$];
  int  mismatches = 0;
  int  sent_items = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;
  bit  in_gaps_on = 1'b0;
  bit  out_stalls_on = 1'b0;
  int  in_gap = 0;
  int  out_stall = 0;
  int  hold_asks = 0;
  int  hold_done = 0;
  int  hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic in_item_t make_item(logic has, logic [FLD_W-1:0] row,
                                         logic [FLD_W-1:0] col,
                                         logic [VAL_W-1:0] value, logic last);
    in_item_t it;
    it.has_term   = has;
    it.term_row   = row;
    it.term_col   = col;
    it.term_value = value;
    it.last_term  = last;
    return it;
  endfunction

  function automatic string describe(out_item_t r);
    return $sformatf("hdr=%0d row=%0d col=%0d value=%0d last=%0d",
                     r.is_header, r.out_row, r.out_col, r.out_value, r.out_last);
  endfunction

  task automatic report_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0d] ERROR: %s", cycle_count, msg);
  endtask

  // Hold the triplet, and on the final item lay out the header and the
  // transposed terms in column order, arrival order kept within a column.
  task automatic transpose_step(in_item_t it);
    triplet_t  t;
    out_item_t res;
    int n, c, i, emitted;
    if (it.has_term && {1'b0, it.term_col} < shape_cols && held_terms.size() < MAX_TERMS)
    begin
      t.row   = it.term_row;
      t.col   = it.term_col;
      t.value = it.term_value;
      held_terms.push_back(t);
    end
    if (it.last_term) begin
      n = held_terms.size();
      res.is_header = 1'b1;
      res.out_row   = shape_cols;
      res.out_col   = shape_rows;
      res.out_value = n;
      res.out_last  = (n == 0);
      transposed_due.push_back(res);
      emitted = 0;
      for (c = 0; c < MAX_DIM; c++) begin
        for (i = 0; i < n; i++) begin
          if (held_terms[i].col == c) begin
            res.is_header = 1'b0;
            res.out_row   = {1'b0, held_terms[i].col};
            res.out_col   = {1'b0, held_terms[i].row};
            res.out_value = held_terms[i].value;
            res.out_last  = (emitted == n - 1);
            transposed_due.push_back(res);
            emitted++;
          end
        end
      end
      held_terms.delete();
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (transposed_due.size() == 0) begin
      report_error({"unexpected result: ", describe(got)});
      return;
    end
    want = transposed_due.pop_front();
    if (got.is_header !== want.is_header || got.out_row !== want.out_row ||
        got.out_col !== want.out_col || got.out_value !== want.out_value ||
        got.out_last !== want.out_last)
      report_error({"expected ", describe(want), " got ", describe(got)});
  endtask

  // transfer monitor and checker
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst) begin
      shape_rows = 7'd64;
      shape_cols = 7'd64;
      held_terms.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_ROW_COUNT) shape_rows = cfg_data;
        else shape_cols = cfg_data;
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        transpose_step(in_data);
      end
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (matrix_feed.size() > 0) begin
        in_data  <= matrix_feed.pop_front();
        in_valid <= 1'b1;
        sent_items++;
        in_gap = in_gaps_on ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asks) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_asks;
    end
  end

  // output receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0 || out_stall > 0) begin
      out_ready <= 1'b0;
      if (out_stall > 0) out_stall--;
    end else begin
      out_ready <= 1'b1;
      if (out_stalls_on && $urandom_range(0, 3) == 0) out_stall = idle_len();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** sparse_triplet_fast_transpose: FAILED **");
      $finish;
    end
  end

  task automatic set_shape(logic [REG_W-1:0] rows, logic [REG_W-1:0] cols);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= rows;
    @(negedge clk);
    cfg_index <= REG_COL_COUNT;
    cfg_data  <= cols;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // wait for the block to drain, then past its column clear
  task automatic settle();
    while (matrix_feed.size() != 0 || in_valid || transposed_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [FLD_W-1:0] pick_col(int lim);
    if (lim == 0 || $urandom_range(0, 9) == 0) return FLD_W'($urandom_range(0, 63));
    if ($urandom_range(0, 1)) return FLD_W'($urandom_range(0, lim - 1));
    return FLD_W'($urandom_range(0, (lim < 4 ? lim : 4) - 1));
  endfunction

  task automatic queue_matrix(int terms, bit dense);
    int i, lim;
    logic has;
    logic [FLD_W-1:0] col;
    lim = (shape_cols > MAX_DIM) ? MAX_DIM : shape_cols;
    for (i = 0; i < terms; i++) begin
      has = dense || $urandom_range(0, 9) != 0;
      col = dense ? FLD_W'($urandom_range(0, lim - 1)) : pick_col(lim);
      matrix_feed.push_back(make_item(has, FLD_W'($urandom_range(0, 63)), col,
                                      $urandom, 1'b0));
    end
    matrix_feed.push_back(make_item(1'($urandom_range(0, 1)),
                                    FLD_W'($urandom_range(0, 63)),
                                    pick_col(lim), $urandom, 1'b1));
  endtask

  int shape_row_set[6] = '{64, 1, 33, 64, 7, 64};
  int shape_col_set[6] = '{64, 1, 12, 64, 64, 30};

  initial begin
    int phase, k, n;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    set_shape(7'd64, 7'd64);

    // empty matrix, then column extremes, value extremes, stable columns
    matrix_feed.push_back(make_item(1'b0, 6'd21, 6'd42, $urandom, 1'b1));
    matrix_feed.push_back(make_item(1'b1, 6'd0, 6'd0, 32'h8000_0000, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd63, 6'd63, 32'h7FFF_FFFF, 1'b0));
    matrix_feed.push_back(make_item(1'b0, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd5, 6'd63, 32'hFFFF_FFFF, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd7, 6'd0, 32'h0000_0000, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd63, 6'd0, 32'h0000_0001, 1'b1));
    settle();

    // columns at and past col_count dropped; matrix left open at the end
    set_shape(7'd1, 7'd5);
    matrix_feed.push_back(make_item(1'b1, 6'd1, 6'd5, 32'h1234_5678, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd2, 6'd4, 32'hCAFE_0001, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd3, 6'd63, 32'h5555_AAAA, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd4, 6'd0, 32'hAAAA_5555, 1'b0));
    matrix_feed.push_back(make_item(1'b0, 6'd0, 6'd0, 32'h0, 1'b1));
    matrix_feed.push_back(make_item(1'b1, 6'd3, 6'd4, 32'h0BAD_F00D, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd2, 6'd10, 32'h0000_0010, 1'b0));
    settle();

    // shape changed with terms held
    set_shape(7'd127, 7'd64);
    matrix_feed.push_back(make_item(1'b1, 6'd9, 6'd10, 32'hFEDC_BA98, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd62, 6'd40, 32'h0F0F_F0F0, 1'b1));
    settle();

    set_shape(7'd64, 7'd0);
    matrix_feed.push_back(make_item(1'b1, 6'd1, 6'd0, 32'h1, 1'b0));
    matrix_feed.push_back(make_item(1'b1, 6'd2, 6'd0, 32'h2, 1'b1));
    settle();
    set_shape(7'd0, 7'd127);
    matrix_feed.push_back(make_item(1'b1, 6'd0, 6'd63, 32'h3, 1'b0));
    matrix_feed.push_back(make_item(1'b0, 6'd63, 6'd0, 32'h4, 1'b1));
    settle();

    phase = 0;
    while (sent_items < 120) begin
      set_shape(REG_W'(shape_row_set[phase % 6]), REG_W'(shape_col_set[phase % 6]));
      in_gaps_on    = (phase != 1);
      out_stalls_on = (phase != 1);
      if (phase == 0) hold_asks++;
      for (k = 0; k < 3; k++) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
        queue_matrix(n, 1'b0);
      end
      // more terms than the store holds
      if (phase == 0) queue_matrix(66, 1'b1);
      settle();
      phase++;
    end

    if (mismatches == 0 && transposed_due.size() == 0) begin
      $display("** sparse_triplet_fast_transpose: PASSED **");
    end else begin
      if (transposed_due.size() != 0)
        $display("ERROR: %0d results never arrived", transposed_due.size());
      $display("** sparse_triplet_fast_transpose: FAILED **");
    end
    $finish;
  end

endmodule

@@ sparse_triplet_fast_transpose.f @@
design/sptr_pkg.sv
design/sptr_ram.sv
design/sptr_outq.sv
design/sptr_ctrl.sv
design/sparse_triplet_fast_transpose.sv
sim/tb_top.sv
